// ----- rtl/core/ccs_pkg.sv -----
package ccs_pkg;

   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

   typedef struct packed {
      logic       stream_end;
      logic       run_last;
      logic       out_valid;
      logic [7:0] out_char;
   } beat_type;

   function automatic beat_type char_beat(input logic [7:0] ch);
      beat_type b;
      b            = '0;
      b.out_char   = ch;
      b.out_valid  = 1'b1;
      return b;
   endfunction

endpackage

// ----- rtl/core/c_comment_stripper.sv -----
// Streaming C comment stripper. One source byte enters per beat on req_ and
// the kept bytes leave on rsp_. Line comments are dropped up to their newline
// (the newline stays), block comments are dropped whole, and string and
// character literals pass unchanged. A slash is held for one byte until it is
// known not to open a comment. A byte is accepted every cycle while rsp_ keeps
// up; a byte that releases a held slash yields two result beats, and the next
// byte then waits until the first has left the two-entry result queue. Each
// input beat yields zero, one or two result beats (rsp_tlast marks the last);
// a stream's final byte sets stream_end on its last beat, a bare one if none.
module c_comment_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [1:0] rsp_tuser,   // [0] out_valid, [1] stream_end
   output logic       rsp_tlast    // run_last
);

   typedef enum logic [3:0] {
      MODE_NORMAL   = 4'd0,
      MODE_SLASH    = 4'd1,
      MODE_STR      = 4'd2,
      MODE_STR_ESC  = 4'd3,
      MODE_CHR      = 4'd4,
      MODE_CHR_ESC  = 4'd5,
      MODE_LINE     = 4'd6,
      MODE_LINE_ESC = 4'd7,
      MODE_BLK      = 4'd8,
      MODE_BLK_STAR = 4'd9
   } mode_type;

   mode_type           mode_ff, mode_in;
   ccs_pkg::beat_type  q_ff [2];
   ccs_pkg::beat_type  q_in [2];
   logic [1:0]         cnt_ff, cnt_in;
   ccs_pkg::beat_type  res [2];
   logic [1:0]         n;
   logic               accept;
   logic               pop;
   logic [7:0]         c;

   assign c          = req_tdata;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tdata  = q_ff[0].out_char;
   assign rsp_tuser  = {q_ff[0].stream_end, q_ff[0].out_valid};
   assign rsp_tlast  = q_ff[0].run_last;

   always_comb begin
      mode_in = mode_ff;
      res[0]  = '0;
      res[1]  = '0;
      n       = 2'd0;
      case (mode_ff)
         MODE_SLASH: begin
            if (c == ccs_pkg::CHAR_SLASH) begin
               mode_in = MODE_LINE;
            end else if (c == ccs_pkg::CHAR_STAR) begin
               mode_in = MODE_BLK;
            end else begin
               res[0] = ccs_pkg::char_beat(ccs_pkg::CHAR_SLASH);
               res[1] = ccs_pkg::char_beat(c);
               n      = 2'd2;
               if (c == ccs_pkg::CHAR_DQUOTE) begin
                  mode_in = MODE_STR;
               end else if (c == ccs_pkg::CHAR_SQUOTE) begin
                  mode_in = MODE_CHR;
               end else begin
                  mode_in = MODE_NORMAL;
               end
            end
         end
         MODE_STR: begin
            res[0] = ccs_pkg::char_beat(c);
            n      = 2'd1;
            if (c == ccs_pkg::CHAR_DQUOTE || c == ccs_pkg::CHAR_NEWLINE) begin
               mode_in = MODE_NORMAL;
            end else if (c == ccs_pkg::CHAR_BACKSLASH) begin
               mode_in = MODE_STR_ESC;
            end
         end
         MODE_STR_ESC: begin
            res[0]  = ccs_pkg::char_beat(c);
            n       = 2'd1;
            mode_in = MODE_STR;
         end
         MODE_CHR: begin
            res[0] = ccs_pkg::char_beat(c);
            n      = 2'd1;
            if (c == ccs_pkg::CHAR_SQUOTE || c == ccs_pkg::CHAR_NEWLINE) begin
               mode_in = MODE_NORMAL;
            end else if (c == ccs_pkg::CHAR_BACKSLASH) begin
               mode_in = MODE_CHR_ESC;
            end
         end
         MODE_CHR_ESC: begin
            res[0]  = ccs_pkg::char_beat(c);
            n       = 2'd1;
            mode_in = (c == ccs_pkg::CHAR_NEWLINE) ? MODE_NORMAL : MODE_CHR;
         end
         MODE_LINE: begin
            if (c == ccs_pkg::CHAR_NEWLINE) begin
               res[0]  = ccs_pkg::char_beat(c);
               n       = 2'd1;
               mode_in = MODE_NORMAL;
            end else if (c == ccs_pkg::CHAR_BACKSLASH) begin
               mode_in = MODE_LINE_ESC;
            end
         end
         MODE_LINE_ESC: begin
            mode_in = MODE_LINE;
         end
         MODE_BLK: begin
            if (c == ccs_pkg::CHAR_STAR) begin
               mode_in = MODE_BLK_STAR;
            end
         end
         MODE_BLK_STAR: begin
            if (c == ccs_pkg::CHAR_SLASH) begin
               mode_in = MODE_NORMAL;
            end else if (c != ccs_pkg::CHAR_STAR) begin
               mode_in = MODE_BLK;
            end
         end
         default: begin
            if (c == ccs_pkg::CHAR_SLASH) begin
               mode_in = MODE_SLASH;
            end else begin
               res[0] = ccs_pkg::char_beat(c);
               n      = 2'd1;
               if (c == ccs_pkg::CHAR_DQUOTE) begin
                  mode_in = MODE_STR;
               end else if (c == ccs_pkg::CHAR_SQUOTE) begin
                  mode_in = MODE_CHR;
               end else begin
                  mode_in = MODE_NORMAL;
               end
            end
         end
      endcase

      // flush a held slash and close the stream
      if (req_tlast) begin
         if (mode_in == MODE_SLASH) begin
            res[n[0]] = ccs_pkg::char_beat(ccs_pkg::CHAR_SLASH);
            n         = n + 2'd1;
         end
         if (n == 2'd0) begin
            res[0] = '0;
            n      = 2'd1;
         end
         res[n[1]].stream_end = 1'b1;
         mode_in              = MODE_NORMAL;
      end
      if (n != 2'd0) begin
         res[n[1]].run_last = 1'b1;
      end
   end

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (accept) begin
         q_in[0] = res[0];
         q_in[1] = res[1];
         cnt_in  = n;
      end else if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         cnt_ff  <= 2'd0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
         end
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_last_resets_mode: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> mode_ff == MODE_NORMAL)
      else $error("mode not normal after final byte");

   a_pair_head_not_last: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !q_ff[0].run_last)
      else $error("first of a beat pair marked run_last");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && q_ff[0].stream_end |-> q_ff[0].run_last)
      else $error("stream_end without run_last");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !q_ff[0].out_valid |->
         q_ff[0].stream_end && q_ff[0].out_char == 8'd0)
      else $error("bare beat is not a clean end marker");
`endif

endmodule
